[design/dht_pkg.sv]
package dht_pkg;

   // Commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam logic [63:0] HASH_START = 64'd5381;
   localparam int HASH_SHIFT = 5;

   typedef struct packed {
      logic        command;
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_value;
      logic [10:0] stored_count;
   } rsp_type;

   // Front-to-back job: hashed, trimmed key
   typedef struct packed {
      logic        command;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] value;
      logic [63:0] hash;
   } job_type;

endpackage

[design/dht_front.sv]
// Front: trims the key and hashes it one character per cycle.
module dht_front #(
   parameter int KEY_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dht_pkg::req_type  in_item,
   output logic              job_valid,
   input  logic              job_ready,
   output dht_pkg::job_type  job
);
   import dht_pkg::*;

   localparam int CW = $clog2(KEY_BYTES + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [CW-1:0]   lim_ff, lim_in;
   job_type         job_ff, job_in;
   logic [7:0]      ch;

   assign in_ready  = !busy_ff;
   assign job_valid = busy_ff && done_ff;
   assign job       = job_ff;
   assign ch        = job_ff.key[pos_ff[CW-1:0]*8 +: 8];

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      pos_in  = pos_ff;
      lim_in  = lim_ff;
      job_in  = job_ff;
      if (!busy_ff) begin
         if (in_valid) begin
            busy_in       = 1'b1;
            done_in       = 1'b0;
            pos_in        = '0;
            lim_in        = (in_item.key_length > 4'(KEY_BYTES)) ? CW'(KEY_BYTES)
                                                                 : CW'(in_item.key_length);
            job_in.command = in_item.command;
            job_in.key     = in_item.key_bytes;
            job_in.value   = in_item.entry_value;
            job_in.hash    = HASH_START;
            job_in.len     = '0;
         end
      end else if (!done_ff) begin
         // one character per cycle; stop at limit or a zero byte
         if (pos_ff == lim_ff || ch == 8'd0) begin
            done_in    = 1'b1;
            job_in.len = 4'(pos_ff);
            for (int b = 0; b < 8; b++) begin
               if (b >= int'(pos_ff)) job_in.key[b*8 +: 8] = 8'd0;
            end
         end else begin
            job_in.hash = (job_ff.hash << HASH_SHIFT) + job_ff.hash + 64'(ch);
            pos_in      = pos_ff + 1'b1;
         end
      end else if (job_ready) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      pos_ff <= pos_in;
      lim_ff <= lim_in;
      job_ff <= job_in;
   end

endmodule

[design/dht_queue.sv]
// Two-entry queue between front and back.
module dht_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dht_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output dht_pkg::job_type out_job
);
   import dht_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job   = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= in_job;
   end

endmodule

[design/dht_back.sv]
// Back: modulo reduction, then slot probes with a read and a check state each.
module dht_back #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [10:0]      slots_cfg,
   input  logic             job_valid,
   output logic             job_ready,
   input  dht_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output dht_pkg::rsp_type out_item
);
   import dht_pkg::*;

   localparam int AW = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
   localparam int NW = $clog2(TABLE_SLOTS + 1);
   localparam int CW = 11;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;
   localparam logic [2:0] S_CLR  = 3'd5;

   // slot memories
   logic [63:0]  key_mem   [TABLE_SLOTS];
   logic [3:0]   len_mem   [TABLE_SLOTS];
   logic [31:0]  val_mem   [TABLE_SLOTS];
   logic         used_mem  [TABLE_SLOTS];
   logic [63:0]  rd_key_ff;
   logic [3:0]   rd_len_ff;
   logic [31:0]  rd_val_ff;
   logic         rd_used_ff;

   logic [2:0]    state_ff;
   job_type       job_ff;
   logic [NW-1:0] n_ff;
   // serial remainders of hash by n and n-1
   logic [NW:0]   rn_ff, rm_ff;
   logic [6:0]    bit_ff;
   logic [NW-1:0] step_ff, slot_ff;
   logic [NW-1:0] probes_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] clr_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          wr_en;
   logic [NW-1:0] n_eff, nm1;
   logic [NW:0]   rn_sh, rm_sh, slot_sum;
   logic          hb;

   always_comb begin
      if (slots_cfg < 11'd2) n_eff = NW'(2);
      else if ({21'd0, slots_cfg} > 32'(TABLE_SLOTS)) n_eff = NW'(TABLE_SLOTS);
      else n_eff = NW'(slots_cfg);
   end

   assign nm1      = n_ff - 1'b1;
   assign hb       = job_ff.hash[bit_ff[5:0]];
   assign rn_sh    = {rn_ff[NW-1:0], hb};
   assign rm_sh    = {rm_ff[NW-1:0], hb};
   assign slot_sum = {1'b0, slot_ff} + {1'b0, step_ff};
   assign job_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;
   assign wr_en = (state_ff == S_CHK) && !rd_used_ff && (job_ff.command == CMD_INSERT);

   // memory ports
   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem[slot_ff[AW-1:0]];
      rd_len_ff  <= len_mem[slot_ff[AW-1:0]];
      rd_val_ff  <= val_mem[slot_ff[AW-1:0]];
      rd_used_ff <= used_mem[slot_ff[AW-1:0]];
      if (state_ff == S_CLR) begin
         used_mem[clr_ff] <= 1'b0;
      end else if (wr_en) begin
         used_mem[slot_ff[AW-1:0]] <= 1'b1;
         key_mem[slot_ff[AW-1:0]]  <= job_ff.key;
         len_mem[slot_ff[AW-1:0]]  <= job_ff.len;
         val_mem[slot_ff[AW-1:0]]  <= job_ff.value;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && out_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(TABLE_SLOTS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (job_valid && !rsp_valid_ff) begin
                  job_ff   <= job;
                  n_ff     <= n_eff;
                  rn_ff    <= '0;
                  rm_ff    <= '0;
                  bit_ff   <= 7'd63;
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               // restoring remainder, one hash bit per cycle
               rn_ff <= (rn_sh >= {1'b0, n_ff}) ? rn_sh - {1'b0, n_ff} : rn_sh;
               rm_ff <= (rm_sh >= {1'b0, nm1}) ? rm_sh - {1'b0, nm1} : rm_sh;
               if (bit_ff == 7'd0) begin
                  state_ff <= S_READ;
                  probes_ff <= '0;
               end
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == 7'd0) begin
                  slot_ff <= ((rn_sh >= {1'b0, n_ff}) ? NW'(rn_sh - {1'b0, n_ff})
                                                      : NW'(rn_sh));
                  step_ff <= ((rm_sh >= {1'b0, nm1}) ? NW'(rm_sh - {1'b0, nm1})
                                                     : NW'(rm_sh)) + 1'b1;
               end
            end
            S_READ: state_ff <= S_CHK;
            S_CHK: begin
               rsp_ff.found_value <= '0;
               if (!rd_used_ff) begin
                  if (job_ff.command == CMD_INSERT) begin
                     rsp_ff.status <= ST_INSERTED;
                     count_ff      <= count_ff + 1'b1;
                  end else begin
                     rsp_ff.status <= ST_NOT_FOUND;
                  end
                  state_ff <= S_OUT;
               end else if (rd_len_ff == job_ff.len && rd_key_ff == job_ff.key) begin
                  if (job_ff.command == CMD_INSERT) rsp_ff.status <= ST_DUPLICATE;
                  else begin
                     rsp_ff.status      <= ST_FOUND;
                     rsp_ff.found_value <= rd_val_ff;
                  end
                  state_ff <= S_OUT;
               end else if (probes_ff == n_ff - 1'b1) begin
                  rsp_ff.status <= (job_ff.command == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                  state_ff <= S_OUT;
               end else begin
                  probes_ff <= probes_ff + 1'b1;
                  slot_ff   <= (slot_sum >= {1'b0, n_ff}) ? NW'(slot_sum - {1'b0, n_ff})
                                                          : NW'(slot_sum);
                  state_ff  <= S_READ;
               end
            end
            S_OUT: begin
               rsp_ff.stored_count <= count_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[design/double_hash_table_engine.sv]
// Double-hashing key/value table. The front trims each key and hashes it with
// djb2, one character per cycle; the back reduces the hash by bit-serial modulo
// (one hash bit per cycle) and then probes the slot memory, with a read state
// and a check state per probe, up to n probes. A waiting result holds the back
// until it is popped. After reset a clearing pass over all TABLE_SLOTS slots
// runs before the first item reaches the table.
module double_hash_table_engine #(
   parameter int TABLE_SLOTS = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dht_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output dht_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_slots_in_use
);
   import dht_pkg::*;

   logic [10:0] slots_ff;
   logic        f_ready, f_valid, q_ready, q_valid, b_ready, b_valid;
   job_type     f_job, q_job;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) slots_ff <= 11'd1024;
      else if (csr_valid) slots_ff <= csr_slots_in_use;
   end

   assign full = !f_ready;

   dht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .in_valid(push), .in_ready(f_ready), .in_item(req_item),
      .job_valid(f_valid), .job_ready(q_ready), .job(f_job));

   dht_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(q_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(b_ready), .out_job(q_job));

   dht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock, .reset, .slots_cfg(slots_ff), .job_valid(q_valid), .job_ready(b_ready),
      .job(q_job), .out_valid(b_valid), .out_ready(pop), .out_item(rsp_item));

   assign empty = !b_valid;

endmodule

[design/dht_checker.sv]
module dht_checker (
   input logic             clock,
   input logic             reset,
   input logic             empty,
   input logic             pop,
   input dht_pkg::rsp_type rsp_item
);
   import dht_pkg::*;

   // waiting result holds while not taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(rsp_item))
      else $error("result changed while waiting");

   a_status: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_item.status <= ST_NOT_FOUND)
      else $error("bad status");

   a_value: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.status != ST_FOUND |-> rsp_item.found_value == 32'd0)
      else $error("nonzero value without hit");

   a_count: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_item.stored_count <= 11'd1024)
      else $error("count out of range");

endmodule

bind double_hash_table_engine dht_checker u_dht_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop), .rsp_item(rsp_item));

[bench/testbench.sv]
module testbench;
   import dht_pkg::*;

   // Tracks the table contents and the queue of responses still owed
   class table_scoreboard;
      logic [10:0] slots_reg;
      bit          used[1024];
      logic [63:0] keys[1024];
      logic [3:0]  lens[1024];
      logic [31:0] vals[1024];
      logic [10:0] count;
      rsp_type     pending[$];

      function new();
         slots_reg = 11'd1024;
         count = '0;
         foreach (used[i]) used[i] = 1'b0;
      endfunction

      // Work out the response for one accepted request and queue it
      function void note_request(req_type r);
         logic [63:0] key;
         logic [63:0] h;
         logic [63:0] c;
         logic [3:0]  len;
         int unsigned n, stp, base, j;
         bit          done;
         rsp_type     res;
         key = '0;
         h = HASH_START;
         done = 0;
         len = (r.key_length > 4'd8) ? 4'd8 : r.key_length;
         // key ends at the first zero character
         for (int k = 0; k < 8; k++) begin
            if (k < len) begin
               c = (r.key_bytes >> (8 * k)) & 64'hFF;
               if (c == 0) begin
                  len = 4'(k);
                  break;
               end
               key |= c << (8 * k);
               h = (h << 5) + h + c;
            end
         end
         n = (slots_reg < 2) ? 2 : (slots_reg > 1024) ? 1024 : slots_reg;
         stp = 1 + int'(h % (n - 1));
         base = int'(h % n);
         res.status = (r.command == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
         res.found_value = '0;
         for (int unsigned i = 0; i < n && !done; i++) begin
            j = (base + (i * stp) % n) % n;
            if (!used[j]) begin
               if (r.command == CMD_INSERT) begin
                  used[j] = 1'b1;
                  keys[j] = key;
                  lens[j] = len;
                  vals[j] = r.entry_value;
                  count = count + 1'b1;
                  res.status = ST_INSERTED;
               end else begin
                  res.status = ST_NOT_FOUND;
               end
               done = 1;
            end else if (lens[j] == len && keys[j] == key) begin
               if (r.command == CMD_INSERT) begin
                  res.status = ST_DUPLICATE;
               end else begin
                  res.status = ST_FOUND;
                  res.found_value = vals[j];
               end
               done = 1;
            end
         end
         res.stored_count = count;
         pending.push_back(res);
      endfunction

      // Compare one response with the oldest one owed; empty string if good
      function string check_response(rsp_type got);
         rsp_type exp;
         string   msg;
         if (pending.size() == 0) return "response with nothing pending";
         exp = pending.pop_front();
         msg = "";
         if (got.status !== exp.status)
            msg = {msg, $sformatf(" status %0d exp %0d", got.status, exp.status)};
         if (got.found_value !== exp.found_value)
            msg = {msg, $sformatf(" value %h exp %h", got.found_value, exp.found_value)};
         if (got.stored_count !== exp.stored_count)
            msg = {msg, $sformatf(" count %0d exp %0d", got.stored_count, exp.stored_count)};
         return msg;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   req_type     req_item;
   logic        empty;
   logic        pop;
   rsp_type     rsp_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_slots_in_use;

   table_scoreboard board;
   int          errors;
   int          send_idle_pct;
   int          recv_stall_pct;
   longint      cycles;
   logic [63:0] pool_bytes[24];
   logic [3:0]  pool_len[24];

   localparam longint CYCLE_LIMIT = 64'd20000000;

   double_hash_table_engine uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_slots_in_use(csr_slots_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task report(input string msg);
      $display("mismatch at cycle %0d:%s", cycles, msg);
      errors++;
   endtask

   // Timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: check accepted items, stall at random
   initial begin
      string msg;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            msg = board.check_response(rsp_item);
            if (msg != "") report(msg);
         end
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Present one request and hold it until accepted
   task send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (full);
      board.note_request(r);
   endtask

   task wait_drained();
      push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task write_slot_count(input logic [10:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_slots_in_use <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.slots_reg = v;
   endtask

   function req_type make_req(logic cmd, logic [63:0] kb, logic [3:0] kl, logic [31:0] v);
      req_type r;
      r.command = cmd;
      r.key_bytes = kb;
      r.key_length = kl;
      r.entry_value = v;
      return r;
   endfunction

   // Key of nonzero characters with random junk above its length
   task fresh_key(output logic [63:0] kb, output logic [3:0] kl);
      kb = {$urandom, $urandom};
      kl = 4'($urandom_range(8));
      for (int k = 0; k < 8; k++)
         if (k < kl && kb[8*k +: 8] == 8'h00) kb[8*k +: 8] = 8'h5A;
   endtask

   // Same key spelled another way: zero terminator, long length, or junk
   function req_type pool_req(int idx, logic cmd);
      logic [63:0] kb;
      logic [3:0]  kl;
      kb = pool_bytes[idx];
      kl = pool_len[idx];
      case ($urandom_range(2))
         0: begin
            if (kl < 8) begin
               kb[8*kl +: 8] = 8'h00;
               kl = 4'($urandom_range(15, kl));
            end
         end
         1: if (kl == 8) kl = 4'($urandom_range(15, 8));
         default: ;
      endcase
      return make_req(cmd, kb, kl, $urandom);
   endfunction

   initial begin
      logic [10:0] settings[12];
      logic [63:0] kb;
      logic [3:0]  kl;
      board = new();
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      push = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_slots_in_use = 11'd1024;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty key, extreme keys and values, terminators, duplicates
      send_request(make_req(CMD_SEARCH, 64'h0, 4'd0, 32'h0));
      send_request(make_req(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF));
      send_request(make_req(CMD_SEARCH, 64'h0, 4'd0, 32'h1234));
      send_request(make_req(CMD_INSERT, 64'h0, 4'd0, 32'h1));
      send_request(make_req(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0));
      send_request(make_req(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0));
      send_request(make_req(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h7));
      send_request(make_req(CMD_INSERT, 64'hAA00_0000_0063_6261, 4'd7, 32'h55));
      send_request(make_req(CMD_SEARCH, 64'h0000_0000_0063_6261, 4'd3, 32'h0));
      send_request(make_req(CMD_SEARCH, 64'h0000_0000_0000_6261, 4'd2, 32'h0));
      send_request(make_req(CMD_SEARCH, 64'h0102_0304_0506_0708, 4'd8, 32'h0));
      // Slot count below range behaves as two: fill and overflow
      write_slot_count(11'd0);
      for (int i = 1; i <= 4; i++)
         send_request(make_req(CMD_INSERT, 64'h41 + i, 4'd1, i));
      send_request(make_req(CMD_SEARCH, 64'h42, 4'd1, 32'h0));
      send_request(make_req(CMD_SEARCH, 64'h99, 4'd1, 32'h0));
      write_slot_count(11'd2047);
      send_request(make_req(CMD_SEARCH, 64'h43, 4'd1, 32'h0));
      send_request(make_req(CMD_INSERT, 64'h0102_0304_0506_0708, 4'd8, 32'h8));

      // Random phases over many slot counts and idling patterns
      settings = '{11'd1, 11'd3, 11'd7, 11'd16, 11'd1024, 11'd5, 11'd64,
                   11'd2, 11'd12, 11'd2047, 11'd33, 11'd9};
      for (int p = 0; p < 12; p++) begin
         write_slot_count(settings[p]);
         case (p % 5)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            3: begin send_idle_pct = 31; recv_stall_pct = 31; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         foreach (pool_bytes[i]) begin
            fresh_key(kb, kl);
            pool_bytes[i] = kb;
            pool_len[i] = kl;
         end
         for (int i = 0; i < 125; i++) begin
            if (i == 60 && p == 4) wait_drained();
            if ($urandom_range(9) < 8) begin
               send_request(pool_req($urandom_range(23), logic'($urandom_range(1))));
            end else begin
               fresh_key(kb, kl);
               send_request(make_req(logic'($urandom_range(1)), kb, kl, $urandom));
            end
         end
      end

      // Wind down and give the verdict
      push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
